// ===== rtl/dqs_pkg.sv =====
package dqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_READ_KTH   = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // per-cell load controls, at most one set in a cycle
    typedef struct packed {
        logic load;       // take the incoming word
        logic take_prev;  // shift toward the back
        logic take_next;  // shift toward the front
    } t_cell_ctl;

endpackage

// ===== rtl/dqs_cell.sv =====
module dqs_cell #(
    parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  dqs_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_prev_word,
    input  logic [DATA_WIDTH-1:0] i_next_word,
    input  logic [CNT_W-1:0]      i_count,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic                  o_match
);
    import dqs_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic                  live;

    // cell holds a stored word when its position is below the count
    assign live = (i_count > CNT_W'(IDX));

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_word <= i_word;
        end else if (i_ctl.take_prev) begin
            r_word <= i_prev_word;
        end else if (i_ctl.take_next) begin
            r_word <= i_next_word;
        end else begin
            r_word <= r_word;
        end
    end

    assign o_word  = r_word;
    assign o_match = live && (r_word == i_word);

endmodule

// ===== rtl/bounded_deque_with_search.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+--------------------------------------------
// command  | i_in_valid  | o_in_ready  | i_cmd, i_value, i_position
// result   | o_out_valid | i_out_ready | o_status, o_data_out, o_found, o_count
//
// one command per cycle while no result beat is stalled; every command finishes in the cycle
// it is accepted and its result beat appears on the next cycle from the output register
// the store is a row of cells, front in cell 0; front pushes and front pops shift the row
// reset clears the count and the output valid; cell contents stay unknown until written
// a stalled result beat holds o_in_ready low until taken, unless taken in the same cycle
module bounded_deque_with_search #(
    parameter int DEPTH      = dqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic [CNT_W-1:0]   i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dqs_pkg::t_status   o_status,
    output logic signed [31:0] o_data_out,
    output logic               o_found,
    output logic [CNT_W-1:0]   o_count
);
    import dqs_pkg::*;

    // control state
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    t_status          r_status;
    t_status          n_status;
    logic [31:0]      r_data;
    logic [31:0]      n_data;
    logic             r_found;
    logic             n_found;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  do_push_front;
    logic                  do_push_back;
    logic                  do_pop_front;
    logic [63:0]           value_ext;
    logic [DATA_WIDTH-1:0] in_word;
    logic [IDX_W-1:0]      rd_idx;
    logic signed [DATA_WIDTH-1:0] rd_word;
    logic [63:0]           rd_ext;
    logic                  pos_bad;

    t_cell_ctl             cell_ctl   [DEPTH];
    logic [DATA_WIDTH-1:0] cell_word  [DEPTH];
    logic [DEPTH-1:0]      cell_match;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    // value kept in its low DATA_WIDTH bits after sign extension
    assign value_ext = 64'(i_value);
    assign in_word   = value_ext[DATA_WIDTH-1:0];

    assign do_push_front = accept && (t_cmd'(i_cmd) == CMD_PUSH_FRONT) && !full;
    assign do_push_back  = accept && (t_cmd'(i_cmd) == CMD_PUSH_BACK) && !full;
    assign do_pop_front  = accept && (t_cmd'(i_cmd) == CMD_POP_FRONT) && !empty;

    // cell controls: push front shifts the row back, pop front shifts it forward
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_ctl[k].load      = (do_push_front && (k == 0))
                                 || (do_push_back && (r_count == CNT_W'(k)));
            cell_ctl[k].take_prev = do_push_front && (k != 0);
            cell_ctl[k].take_next = do_pop_front;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dqs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_word      (in_word),
            .i_prev_word ((g == 0) ? in_word : cell_word[(g == 0) ? 0 : g - 1]),
            .i_next_word ((g == DEPTH - 1) ? cell_word[g]
                                           : cell_word[(g == DEPTH - 1) ? g : g + 1]),
            .i_count     (r_count),
            .o_word      (cell_word[g]),
            .o_match     (cell_match[g])
        );
    end

    // one read port over the row: front, back or k-th word
    always_comb begin
        unique case (t_cmd'(i_cmd))
            CMD_POP_BACK: rd_idx = IDX_W'(r_count - CNT_W'(1));
            CMD_READ_KTH: rd_idx = IDX_W'(i_position - CNT_W'(1));
            default:      rd_idx = '0;
        endcase
    end

    assign rd_word = cell_word[rd_idx];
    assign rd_ext  = 64'(rd_word);
    assign pos_bad = (i_position == '0) || (i_position > r_count);

    // next count and result fields
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_data   = '0;
        n_found  = 1'b0;
        unique case (t_cmd'(i_cmd))
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data  = rd_ext[31:0];
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_FIND: begin
                n_found = |cell_match;
            end
            CMD_READ_KTH: begin
                if (pos_bad) begin
                    n_status = ST_RANGE;
                end else begin
                    n_data = rd_ext[31:0];
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_found  <= n_found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_out  = r_data;
    assign o_found     = r_found;
    assign o_count     = r_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && ((t_cmd'(i_cmd) == CMD_PUSH_FRONT)
                         || (t_cmd'(i_cmd) == CMD_PUSH_BACK)))
        |=> (o_status == ST_FULL) && (o_count == CNT_W'(DEPTH)))
        else $error("push on full queue not refused");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_cmd'(i_cmd) == CMD_CLEAR))
        |=> o_out_valid && (o_count == '0) && (o_status == ST_OK))
        else $error("clear did not empty the queue");

    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_data_out == '0) && !o_found)
        else $error("error beat carries data");
`endif

endmodule
